>>> rtl/abd_pkg.sv
// abd_pkg: shared types, constants and the sigmoid table of the anchor box decoder
// no dependencies
package abd_pkg;

    // fixed field widths
    localparam int LOGIT_W   = 16;
    localparam int GRID_W    = 8;
    localparam int ANCHOR_W  = 2;
    localparam int CLASS_W   = 7;
    localparam int EDGE_W    = 24;
    localparam int CONF_W    = 16;
    localparam int SIG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 30;
    localparam int ANC_SIZE_W = 10;

    // arithmetic widths of the shared unit
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 17;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W    = 52;
    localparam int QOFF_W   = 26;

    // saturation bounds of an edge, 1/16 px
    localparam logic signed [QOFF_W-1:0] EDGE_MIN = -26'sd32768;
    localparam logic signed [QOFF_W-1:0] EDGE_MAX = 26'sd8388607;

    // half-unit rounding constant for Q.32 to Q.4
    localparam logic signed [SUM_W-1:0] EDGE_ROUND = 52'sd134217728;

    // sigmoid table end value, used from |x| = 8.0 upward
    localparam logic [SIG_W-1:0] SIG_END = 16'd65514;

    // element count limits
    localparam logic [CLASS_W-1:0] COUNT_MAX  = 7'd127;
    localparam logic [CLASS_W-1:0] FIRST_CLS  = 7'd5;
    localparam logic [CLASS_W-1:0] OBJ_IDX    = 7'd4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_STRIDE    = 3'd1,
        CFG_NCLASSES  = 3'd2,
        CFG_ANC_W     = 3'd3,
        CFG_ANC_H     = 3'd4
    } t_cfg_reg;

    // one input item
    typedef struct packed {
        logic signed [LOGIT_W-1:0]  logit;
        logic [GRID_W-1:0]          grid_x;
        logic [GRID_W-1:0]          grid_y;
        logic [ANCHOR_W-1:0]        anchor;
        logic                       last;
    } t_logit_in;

    // one result item
    typedef struct packed {
        logic signed [EDGE_W-1:0]   box_x1;
        logic signed [EDGE_W-1:0]   box_y1;
        logic signed [EDGE_W-1:0]   box_x2;
        logic signed [EDGE_W-1:0]   box_y2;
        logic [CONF_W-1:0]          confidence;
        logic [CLASS_W-1:0]         class_index;
    } t_box_out;

    // sigmoid(k/2) in Q0.16, k = 0..16
    function automatic logic [SIG_W-1:0] sig_tab(input logic [4:0] k);
        logic [SIG_W-1:0] v;
        case (k)
            5'd0:    v = 16'd32768;
            5'd1:    v = 16'd40793;
            5'd2:    v = 16'd47910;
            5'd3:    v = 16'd53581;
            5'd4:    v = 16'd57724;
            5'd5:    v = 16'd60565;
            5'd6:    v = 16'd62428;
            5'd7:    v = 16'd63615;
            5'd8:    v = 16'd64357;
            5'd9:    v = 16'd64816;
            5'd10:   v = 16'd65097;
            5'd11:   v = 16'd65269;
            5'd12:   v = 16'd65374;
            5'd13:   v = 16'd65438;
            5'd14:   v = 16'd65476;
            5'd15:   v = 16'd65500;
            default: v = SIG_END;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/abd_sigmoid.sv
// abd_sigmoid: table sigmoid with linear interpolation, Q8.8 in, Q0.16 out
// depends on abd_pkg
module abd_sigmoid
    import abd_pkg::*;
(
    input  logic signed [LOGIT_W-1:0] i_logit,
    output logic [SIG_W-1:0]          o_sig
);

    logic                neg;
    logic [LOGIT_W:0]    ext;
    logic [LOGIT_W:0]    mag;
    logic [3:0]          seg;
    logic [6:0]          frac;
    logic [SIG_W-1:0]    lo;
    logic [SIG_W-1:0]    hi;
    logic [SIG_W-1:0]    diff;
    logic [19:0]         step;
    logic [SIG_W-1:0]    pos;

    // magnitude of the logit, one extra bit for the most negative code
    assign neg  = i_logit[LOGIT_W-1];
    assign ext  = {i_logit[LOGIT_W-1], i_logit};
    assign mag  = neg ? ((LOGIT_W+1)'(0) - ext) : ext;
    assign seg  = mag[10:7];
    assign frac = mag[6:0];

    // neighboring table points and interpolation, step rounded half up
    assign lo   = sig_tab({1'b0, seg});
    assign hi   = sig_tab({1'b0, seg} + 5'd1);
    assign diff = hi - lo;
    assign step = 20'(diff) * 20'(frac) + 20'd64;

    // saturate from |x| = 8.0 upward
    always_comb begin
        if (mag[LOGIT_W:11] != '0) begin
            pos = SIG_END;
        end else begin
            pos = lo + SIG_W'(step[19:7]);
        end
    end

    // mirror for negative logits
    assign o_sig = neg ? SIG_W'(17'h10000 - {1'b0, pos}) : pos;

endmodule

>>> rtl/anchor_box_decoder_top.sv
// Class logits are taken one item per cycle while o_in_stall is low. The last item of a
// vector that passes the objectness threshold starts a decode through the sigmoid, multiply,
// edge and done states, with o_in_stall high; the done state loads the result into the
// output register once it is free. Throughput is set by the shared sigmoid unit and the
// single 33x17 multiplier. Items stall only during a decode. Synchronous active-low reset
// clears the sequencer, element count, best class and output valid, and loads config defaults.
module anchor_box_decoder_top
    import abd_pkg::*;
#(
    parameter int MAX_CLASSES = 80,
    parameter int NUM_ANCHORS = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_logit_in              i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_box_out               o_out,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic [CLASS_W-1:0] MAX_CLS = CLASS_W'(MAX_CLASSES);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SIG  = 5'b00010,
        S_MUL  = 5'b00100,
        S_EDGE = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_step, n_step;

    // configuration registers
    logic signed [LOGIT_W-1:0] r_thr;
    logic [6:0]                r_stride;
    logic [CLASS_W-1:0]        r_ncls_cfg;
    logic [CFG_DATA_W-1:0]     r_anc_w;
    logic [CFG_DATA_W-1:0]     r_anc_h;

    // element state
    logic [CLASS_W-1:0]        r_count;
    logic signed [LOGIT_W-1:0] r_box [4];
    logic signed [LOGIT_W-1:0] r_obj;
    logic signed [LOGIT_W-1:0] r_best_logit;
    logic [CLASS_W-1:0]        r_best_class;

    // decode state
    logic [GRID_W-1:0]         r_gx;
    logic [GRID_W-1:0]         r_gy;
    logic [ANC_SIZE_W-1:0]     r_aw;
    logic [ANC_SIZE_W-1:0]     r_ah;
    logic [SIG_W-1:0]          r_sig [6];
    logic signed [MUL_P_W-1:0] r_prod;
    logic signed [MUL_P_W-1:0] r_mres [7];
    logic signed [EDGE_W-1:0]  r_edge [4];
    t_box_out                  r_out;
    logic                      r_out_valid;

    logic                      in_acc;
    logic                      out_acc;
    logic                      trigger;
    logic [CLASS_W-1:0]        ncls;
    logic [CLASS_W-1:0]        cls;
    logic                      take_cls;
    logic [ANC_SIZE_W-1:0]     sel_aw;
    logic [ANC_SIZE_W-1:0]     sel_ah;
    logic signed [LOGIT_W-1:0] sig_in;
    logic [SIG_W-1:0]          sig_out;
    logic signed [25:0]        bx;
    logic signed [25:0]        by;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [SUM_W-1:0]   cx;
    logic signed [SUM_W-1:0]   cy;
    logic signed [SUM_W-1:0]   hw;
    logic signed [SUM_W-1:0]   hh;
    logic signed [SUM_W-1:0]   base;
    logic signed [SUM_W-1:0]   half;
    logic signed [SUM_W-1:0]   vsum;
    logic signed [QOFF_W-1:0]  qoff;
    logic signed [EDGE_W-1:0]  qsat;
    logic [32:0]               conf_sum;
    logic [CONF_W-1:0]         conf;
    logic                      load_out;

    // handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // class count clamped to 1..MAX_CLASSES
    always_comb begin
        if (r_ncls_cfg == '0) begin
            ncls = 7'd1;
        end else if (r_ncls_cfg > MAX_CLS) begin
            ncls = MAX_CLS;
        end else begin
            ncls = r_ncls_cfg;
        end
    end

    // running first maximum over class logits
    assign cls      = r_count - FIRST_CLS;
    assign take_cls = (r_count >= FIRST_CLS) && (cls < ncls)
                      && ((cls == '0) || (i_in.logit > r_best_logit));

    // decode starts on a full vector whose objectness passes
    assign trigger = in_acc && i_in.last && (r_count >= FIRST_CLS) && (r_obj >= r_thr);

    // anchor size select, unknown anchors give zero size
    always_comb begin
        case (i_in.anchor)
            2'd0: begin
                sel_aw = r_anc_w[9:0];
                sel_ah = r_anc_h[9:0];
            end
            2'd1: begin
                sel_aw = r_anc_w[19:10];
                sel_ah = r_anc_h[19:10];
            end
            2'd2: begin
                sel_aw = r_anc_w[29:20];
                sel_ah = r_anc_h[29:20];
            end
            default: begin
                sel_aw = '0;
                sel_ah = '0;
            end
        endcase
        if (32'(i_in.anchor) >= NUM_ANCHORS) begin
            sel_aw = '0;
            sel_ah = '0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= '0;
            r_stride   <= 7'd8;
            r_ncls_cfg <= 7'd80;
            r_anc_w    <= '0;
            r_anc_h    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr      <= i_cfg_data[LOGIT_W-1:0];
                CFG_STRIDE:    r_stride   <= i_cfg_data[6:0];
                CFG_NCLASSES:  r_ncls_cfg <= i_cfg_data[CLASS_W-1:0];
                CFG_ANC_W:     r_anc_w    <= i_cfg_data;
                CFG_ANC_H:     r_anc_h    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // element count and best class
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_best_class <= '0;
        end else if (in_acc) begin
            if (i_in.last) begin
                r_count <= '0;
            end else if (r_count != COUNT_MAX) begin
                r_count <= r_count + 7'd1;
            end
            if (take_cls) begin
                r_best_class <= cls;
            end
        end
    end

    // logit storage and decode operands captured on the starting item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (r_count < OBJ_IDX) begin
                r_box[r_count[1:0]] <= i_in.logit;
            end else if (r_count == OBJ_IDX) begin
                r_obj <= i_in.logit;
            end
            if (take_cls) begin
                r_best_logit <= i_in.logit;
            end
        end
        if (trigger) begin
            r_gx <= i_in.grid_x;
            r_gy <= i_in.grid_y;
            r_aw <= sel_aw;
            r_ah <= sel_ah;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (trigger) begin
                    n_state = S_SIG;
                    n_step  = '0;
                end
            end
            S_SIG: begin
                if (r_step == 3'd5) begin
                    n_state = S_MUL;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_MUL: begin
                if (r_step == 3'd7) begin
                    n_state = S_EDGE;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_EDGE: begin
                if (r_step == 3'd3) begin
                    n_state = S_DONE;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // shared sigmoid: x, y, w, h, objectness, class in turn
    always_comb begin
        if (r_step < 3'd4) begin
            sig_in = r_box[r_step[1:0]];
        end else if (r_step == 3'd4) begin
            sig_in = r_obj;
        end else begin
            sig_in = r_best_logit;
        end
    end

    abd_sigmoid u_sig (
        .i_logit (sig_in),
        .o_sig   (sig_out)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_SIG) begin
            r_sig[r_step] <= sig_out;
        end
    end

    // center terms before stride: 2*sig - 0.5 + grid, Q.16
    assign bx = signed'({2'b0, r_gx, 16'b0}) + signed'({9'b0, r_sig[0], 1'b0}) - 26'sd32768;
    assign by = signed'({2'b0, r_gy, 16'b0}) + signed'({9'b0, r_sig[1], 1'b0}) - 26'sd32768;

    // shared multiplier operand select
    always_comb begin
        case (r_step)
            3'd0: begin
                mul_a = signed'({17'b0, r_sig[2]});
                mul_b = signed'({1'b0, r_sig[2]});
            end
            3'd1: begin
                mul_a = signed'({17'b0, r_sig[3]});
                mul_b = signed'({1'b0, r_sig[3]});
            end
            3'd2: begin
                mul_a = signed'({1'b0, r_mres[0][31:0]});
                mul_b = signed'({7'b0, r_aw});
            end
            3'd3: begin
                mul_a = signed'({1'b0, r_mres[1][31:0]});
                mul_b = signed'({7'b0, r_ah});
            end
            3'd4: begin
                mul_a = MUL_A_W'(bx);
                mul_b = signed'({10'b0, r_stride});
            end
            3'd5: begin
                mul_a = MUL_A_W'(by);
                mul_b = signed'({10'b0, r_stride});
            end
            3'd6: begin
                mul_a = signed'({17'b0, r_sig[5]});
                mul_b = signed'({1'b0, r_sig[4]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // product register, then write-back of the registered product into r_mres
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod <= mul_p;
            if (r_step != 3'd0) begin
                r_mres[r_step - 3'd1] <= r_prod;
            end
        end
    end

    // edges in Q.32: center -/+ half size
    assign cx = signed'({r_mres[4][35:0], 16'b0});
    assign cy = signed'({r_mres[5][35:0], 16'b0});
    assign hw = signed'({9'b0, r_mres[2][41:0], 1'b0});
    assign hh = signed'({9'b0, r_mres[3][41:0], 1'b0});

    always_comb begin
        base = r_step[0] ? cy : cx;
        half = r_step[0] ? hh : hw;
        if (r_step[1]) begin
            vsum = base + half + EDGE_ROUND;
        end else begin
            vsum = base - half + EDGE_ROUND;
        end
        qoff = QOFF_W'(signed'(vsum[SUM_W-1:28])) + signed'({3'b0, r_best_class, 16'b0});
        if (qoff < EDGE_MIN) begin
            qsat = EDGE_W'(EDGE_MIN);
        end else if (qoff > EDGE_MAX) begin
            qsat = EDGE_W'(EDGE_MAX);
        end else begin
            qsat = qoff[EDGE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EDGE) begin
            r_edge[r_step[1:0]] <= qsat;
        end
    end

    // confidence, rounded half up and saturated
    assign conf_sum = {1'b0, r_mres[6][31:0]} + 33'd32768;
    assign conf     = conf_sum[32] ? '1 : conf_sum[31:16];

    // output register
    assign load_out = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.box_x1      <= r_edge[0];
            r_out.box_y1      <= r_edge[1];
            r_out.box_x2      <= r_edge[2];
            r_out.box_y2      <= r_edge[3];
            r_out.confidence  <= conf;
            r_out.class_index <= r_best_class;
        end
    end

    // checks
    a_start_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trigger |=> (r_state == S_SIG) && (r_step == 3'd0))
        else $error("decode did not start on a passing vector");

    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.last |=> (r_count == '0))
        else $error("element count not restarted after last item");

    a_sig_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIG) |-> (r_step <= 3'd5))
        else $error("sigmoid step out of range");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished decode did not reach the output register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && i_out_stall |=> (r_state == S_DONE))
        else $error("waiting result would be overwritten");

endmodule
